>>> sv/poly_slew_limiter_unit_assert.svh
// assertion macros used by the checker file
`ifndef POLY_SLEW_LIMITER_UNIT_ASSERT_SVH
`define POLY_SLEW_LIMITER_UNIT_ASSERT_SVH

// consequent checked in the same cycle
`define PSL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("poly slew limiter check failed");

// consequent checked in the cycle after the antecedent
`define PSL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("poly slew limiter check failed");

`endif

>>> sv/psl_pkg.sv
// ----------------------------------------------------------------------------
// psl_pkg
// Constants, register codes and the exponential table of the slew limiter.
// ----------------------------------------------------------------------------
package psl_pkg;

    localparam logic [2:0] REG_SHAPE_BASE = 3'd0;
    localparam logic [2:0] REG_SHAPE_GAIN = 3'd1;
    localparam logic [2:0] REG_RISE_BASE  = 3'd2;
    localparam logic [2:0] REG_RISE_GAIN  = 3'd3;
    localparam logic [2:0] REG_FALL_BASE  = 3'd4;
    localparam logic [2:0] REG_FALL_GAIN  = 3'd5;
    localparam logic [2:0] REG_TIME_STEP  = 3'd6;

    localparam logic [14:0] RST_KNOB      = 15'd8192;
    localparam logic [20:0] RST_TIME_STEP = 21'd5592;

    localparam logic [14:0] ONE_Q14       = 15'd16384;
    // 5 * log2(10) in Q16
    localparam logic [20:0] LOG2_TEN_X5   = 21'd1088530;
    // 4.0 - log2(10) in Q16, keeps the exponent offset positive
    localparam logic [21:0] EXP_OFFSET    = 22'd44438;
    localparam logic signed [17:0] MIX_KNEE = 18'sd20480;
    localparam logic signed [34:0] MIX_BASE = 35'sd335544320;
    localparam logic [60:0] HALF_DIV      = 61'd5 << 36;
    // reciprocal of ten, exact for 32 bit dividends with a shift of 35
    localparam logic [31:0] RECIP_TEN     = 32'hCCCCCCCD;

    typedef logic [14:0] t_ctl;

    // 2^(i/16) in Q16
    function automatic logic [17:0] exp2_lut(input logic [4:0] i);
        logic [17:0] v;
        case (i)
            5'd0:    v = 18'd65536;
            5'd1:    v = 18'd68438;
            5'd2:    v = 18'd71468;
            5'd3:    v = 18'd74632;
            5'd4:    v = 18'd77936;
            5'd5:    v = 18'd81386;
            5'd6:    v = 18'd84990;
            5'd7:    v = 18'd88752;
            5'd8:    v = 18'd92682;
            5'd9:    v = 18'd96785;
            5'd10:   v = 18'd101070;
            5'd11:   v = 18'd105545;
            5'd12:   v = 18'd110218;
            5'd13:   v = 18'd115098;
            5'd14:   v = 18'd120194;
            5'd15:   v = 18'd125515;
            5'd16:   v = 18'd131072;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

    // base + floor(volts*gain / 2^11), clamped to 0..1.0
    function automatic t_ctl ctl_clamp(input logic signed [16:0] base,
                                       input logic signed [31:0] prod);
        logic signed [21:0] sum;
        t_ctl c;
        sum = 22'(base) + 22'(prod >>> 11);
        if (sum < 22'sd0) begin
            c = '0;
        end else if (sum > 22'sd16384) begin
            c = ONE_Q14;
        end else begin
            c = sum[14:0];
        end
        return c;
    endfunction

endpackage

>>> sv/poly_slew_limiter_unit.sv
// ----------------------------------------------------------------------------
// poly_slew_limiter_unit
// Per-channel slew limiter with a linear to exponential shape control.
// ----------------------------------------------------------------------------
// Each input transfer carries one sample of one channel with its control
// voltages; the block moves that channel's held level toward the sample and
// returns the new level, one result per transfer. A sequencer runs the item
// through one shared chain of multipliers, skipping to the end when the
// sample equals the held level or the channel is out of range, and takes no
// new transfer until the result is in the output register; the held levels
// sit in a one-port memory read at accept and written back at the end. A
// finished result waits in the output register while the next transfer is
// taken in. Levels start at zero after reset without a clearing pass.
module poly_slew_limiter_unit
    import psl_pkg::*;
#(
    parameter int NUM_CHANNELS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [3:0]         i_channel,
    input  logic signed [15:0] i_sample_in,
    input  logic signed [15:0] i_shape_voltage,
    input  logic signed [15:0] i_rise_voltage,
    input  logic signed [15:0] i_fall_voltage,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [3:0]         o_out_channel,
    output logic signed [15:0] o_sample_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIFF = 4'd1;
    localparam logic [3:0] S_RC   = 4'd2;
    localparam logic [3:0] S_EXP  = 4'd3;
    localparam logic [3:0] S_MANT = 4'd4;
    localparam logic [3:0] S_RATE = 4'd5;
    localparam logic [3:0] S_X    = 4'd6;
    localparam logic [3:0] S_Y0   = 4'd7;
    localparam logic [3:0] S_Y1   = 4'd8;
    localparam logic [3:0] S_Q    = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    // configuration registers
    logic signed [15:0] r_shape_base, r_shape_gain, r_rise_gain, r_fall_gain;
    logic [14:0]        r_rise_base, r_fall_base;
    logic [20:0]        r_ts;

    // held levels
    logic signed [15:0] mem_level [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_vld;
    logic signed [15:0] r_rd_data;
    logic               r_rd_vld;

    logic [3:0]         r_state;
    logic [3:0]         r_ch;
    logic               r_ch_ok;
    logic signed [15:0] r_tgt, r_shv, r_riv, r_fav;
    logic signed [15:0] r_held;
    logic [15:0]        r_mag;
    logic               r_up;
    t_ctl               r_shape, r_ctl;
    logic [20:0]        r_u;
    logic [17:0]        r_mant;
    logic [30:0]        r_rate;
    logic [29:0]        r_m;
    logic [38:0]        r_xs;
    logic [52:0]        r_acc;
    logic [24:0]        r_n;
    logic signed [15:0] r_res;

    logic               r_ov;
    logic [3:0]         r_out_ch;
    logic signed [15:0] r_out_smp;

    logic in_xfer, cfg_wr, out_load;
    logic [CH_W-1:0] in_addr, ch_addr;

    // per-state datapath
    logic signed [15:0] held;
    logic signed [16:0] diff;
    logic [15:0]        mag;
    logic signed [31:0] shape_prod, rf_prod;
    t_ctl               shape_ctl, rf_ctl;
    logic [35:0]        w_prod;
    logic [21:0]        u_full;
    logic [24:0]        interp_prod;
    logic [17:0]        lut_lo, lut_hi, mant;
    logic [4:0]         e_int;
    logic [2:0]         k_sh;
    logic [18:0]        rnd;
    logic [30:0]        rate;
    logic signed [17:0] mag_off;
    logic signed [33:0] mix_prod;
    logic signed [34:0] mix_full;
    logic [60:0]        x_prod;
    logic [52:0]        p0;
    logic [27:0]        p1;
    logic [59:0]        y_sum;
    logic [60:0]        a_sum;
    logic [56:0]        q_prod;
    logic [21:0]        q_raw;
    logic [15:0]        q_clip;

    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign cfg_wr   = psel && penable && pwrite;
    assign out_load = (r_state == S_DONE) && (!r_ov || !i_out_stall);
    assign in_addr  = CH_W'(i_channel);
    assign ch_addr  = CH_W'(r_ch);

    always_comb begin
        held       = r_rd_vld ? r_rd_data : 16'sd0;
        diff       = {r_tgt[15], r_tgt} - {held[15], held};
        mag        = diff[16] ? 16'(-diff) : diff[15:0];
        shape_prod = r_shv * r_shape_gain;
        shape_ctl  = ctl_clamp({r_shape_base[15], r_shape_base}, shape_prod);
        rf_prod    = r_up ? (r_riv * r_rise_gain) : (r_fav * r_fall_gain);
        rf_ctl     = ctl_clamp(r_up ? {2'b00, r_rise_base} : {2'b00, r_fall_base}, rf_prod);

        w_prod = (ONE_Q14 - r_ctl) * LOG2_TEN_X5;
        u_full = w_prod[35:14] + EXP_OFFSET;

        lut_lo      = exp2_lut({1'b0, r_u[15:12]});
        lut_hi      = exp2_lut({1'b0, r_u[15:12]} + 5'd1);
        interp_prod = (lut_hi - lut_lo) * r_u[11:0];
        mant        = lut_lo + 18'((interp_prod + 25'd2048) >> 12);

        // integer part of the exponent, biased by four
        e_int = r_u[20:16];
        k_sh  = 3'(5'd4 - e_int);
        rnd   = 19'(r_mant) + (19'd1 << (k_sh - 3'd1));
        if (e_int >= 5'd4) begin
            rate = 31'(r_mant) << (e_int - 5'd4);
        end else begin
            rate = 31'(rnd >> k_sh);
        end
        mag_off  = $signed({2'b00, r_mag}) - MIX_KNEE;
        mix_prod = mag_off * $signed({1'b0, r_shape});
        mix_full = MIX_BASE + 35'(mix_prod);

        x_prod = r_rate * r_m;
        p0     = r_xs[31:0] * r_ts;
        p1     = r_xs[38:32] * r_ts;
        y_sum  = 60'(r_acc) + {p1, 32'd0};
        a_sum  = {1'b0, y_sum} + HALF_DIV;

        q_prod = r_n * RECIP_TEN;
        q_raw  = q_prod[56:35];
        q_clip = (q_raw > {6'd0, r_mag}) ? r_mag : q_raw[15:0];
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape_base <= '0;
            r_shape_gain <= '0;
            r_rise_base  <= RST_KNOB;
            r_rise_gain  <= '0;
            r_fall_base  <= RST_KNOB;
            r_fall_gain  <= '0;
            r_ts         <= RST_TIME_STEP;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_SHAPE_BASE: r_shape_base <= pwdata[15:0];
                REG_SHAPE_GAIN: r_shape_gain <= pwdata[15:0];
                REG_RISE_BASE:  r_rise_base  <= pwdata[14:0];
                REG_RISE_GAIN:  r_rise_gain  <= pwdata[15:0];
                REG_FALL_BASE:  r_fall_base  <= pwdata[14:0];
                REG_FALL_GAIN:  r_fall_gain  <= pwdata[15:0];
                REG_TIME_STEP:  r_ts         <= pwdata[20:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_SHAPE_BASE: prdata = 32'($unsigned(r_shape_base));
            REG_SHAPE_GAIN: prdata = 32'($unsigned(r_shape_gain));
            REG_RISE_BASE:  prdata = 32'(r_rise_base);
            REG_RISE_GAIN:  prdata = 32'($unsigned(r_rise_gain));
            REG_FALL_BASE:  prdata = 32'(r_fall_base);
            REG_FALL_GAIN:  prdata = 32'($unsigned(r_fall_gain));
            REG_TIME_STEP:  prdata = 32'(r_ts);
            default:        prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // level memory, read at accept, written when the result leaves
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_rd_data <= mem_level[in_addr];
        end
        if (out_load && r_ch_ok) begin
            mem_level[ch_addr] <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_rd_vld <= r_vld[in_addr];
            end
            if (out_load && r_ch_ok) begin
                r_vld[ch_addr] <= 1'b1;
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (in_xfer) r_state <= S_DIFF;
                S_DIFF: begin
                    if (!r_ch_ok || diff == 17'sd0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_RC;
                    end
                end
                S_RC:   r_state <= S_EXP;
                S_EXP:  r_state <= S_MANT;
                S_MANT: r_state <= S_RATE;
                S_RATE: r_state <= S_X;
                S_X:    r_state <= S_Y0;
                S_Y0:   r_state <= S_Y1;
                S_Y1:   r_state <= S_Q;
                S_Q:    r_state <= S_DONE;
                S_DONE: if (out_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_ch    <= i_channel;
                    r_ch_ok <= (32'(i_channel) < 32'(NUM_CHANNELS));
                    r_tgt   <= i_sample_in;
                    r_shv   <= i_shape_voltage;
                    r_riv   <= i_rise_voltage;
                    r_fav   <= i_fall_voltage;
                end
            end
            S_DIFF: begin
                r_held  <= held;
                r_mag   <= mag;
                r_up    <= !diff[16];
                r_shape <= shape_ctl;
                r_res   <= r_ch_ok ? held : 16'sd0;
            end
            S_RC:   r_ctl  <= rf_ctl;
            S_EXP:  r_u    <= u_full[20:0];
            S_MANT: r_mant <= mant;
            S_RATE: begin
                r_rate <= rate;
                r_m    <= mix_full[29:0];
            end
            S_X:    r_xs   <= x_prod[60:22];
            S_Y0:   r_acc  <= p0;
            S_Y1:   r_n    <= a_sum[60:36];
            S_Q:    r_res  <= r_up ? (r_held + $signed(q_clip)) : (r_held - $signed(q_clip));
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ch  <= r_ch;
            r_out_smp <= r_res;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_ov;
    assign o_out_channel = r_out_ch;
    assign o_sample_out  = r_out_smp;

endmodule

>>> sv/psl_checker.sv
// ----------------------------------------------------------------------------
// psl_checker
// Port-level checks of the slew limiter, bound to the top level.
// ----------------------------------------------------------------------------
`include "poly_slew_limiter_unit_assert.svh"

module psl_checker #(
    parameter int NUM_CHANNELS = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [3:0]         o_out_channel,
    input logic signed [15:0] o_sample_out
);

    // a stalled result holds
    `PSL_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_channel) && $stable(o_sample_out))

    // one item at a time
    `PSL_ASSERT_NEXT(a_one_item, i_in_valid && !o_in_stall, o_in_stall)

    // the output does not become valid straight after a transfer is accepted
    `PSL_ASSERT_NEXT(a_no_early_result, i_in_valid && !o_in_stall, !$rose(o_out_valid))

    // a channel without storage reads as zero
    `PSL_ASSERT_NOW(a_bad_channel_zero, o_out_valid && (32'(o_out_channel) >= 32'(NUM_CHANNELS)), o_sample_out == 16'sd0)

endmodule

bind poly_slew_limiter_unit psl_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_psl_checker (.*);

>>> sim/tb_poly_slew_limiter_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_poly_slew_limiter_unit
// Self-checking bench for the per-channel slew limiter.
// ----------------------------------------------------------------------------
// A short table of hand-picked samples runs first, then random samples in
// several register settings and handshake idle patterns. Every accepted
// transfer is run through a fixed-point predictor of the limiter, and each
// output transfer is compared in order with the predicted channel and level.
module tb_poly_slew_limiter_unit;
    import psl_pkg::*;

    localparam int  NCH       = 16;
    localparam int  N_PHASES  = 8;
    localparam int  PER_PHASE = 100;
    localparam longint unsigned STEP_DIV = 64'd687194767360;

    typedef struct packed {
        logic [3:0]         chan;
        logic signed [15:0] level;
    } t_level;

    typedef struct {
        logic [3:0]         chan;
        logic signed [15:0] target;
        logic signed [15:0] shape_v;
        logic signed [15:0] rise_v;
        logic signed [15:0] fall_v;
        bit                 typed;
        logic signed [15:0] typed_level;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [3:0]         i_channel;
    logic signed [15:0] i_sample_in;
    logic signed [15:0] i_shape_voltage;
    logic signed [15:0] i_rise_voltage;
    logic signed [15:0] i_fall_voltage;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [3:0]         o_out_channel;
    logic signed [15:0] o_sample_out;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    poly_slew_limiter_unit #(.NUM_CHANNELS(NCH)) dut (.*);

    // register mirror
    logic signed [15:0] m_shape_base, m_shape_gain, m_rise_gain, m_fall_gain;
    logic [14:0]        m_rise_base, m_fall_base;
    logic [20:0]        m_time_step;
    logic signed [15:0] chan_level [NCH];

    t_level level_q [$];
    int     errors;
    int     n_sent;
    int     n_checked;
    int     sender_pct;
    int     recv_pct;
    int     hold_req;
    int     hold_seen;
    int     hold_cnt;
    bit     drv_typed;
    logic signed [15:0] drv_typed_level;

    const longint unsigned pow2_frac [17] = '{
        65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752, 92682,
        96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072
    };

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic longint clamp_ctl(longint base, logic signed [15:0] volts,
                                         logic signed [15:0] gain);
        longint c;
        c = base + ((longint'(volts) * longint'(gain)) >>> 11);
        if (c < 0) c = 0;
        if (c > 16384) c = 16384;
        return c;
    endfunction

    // 10000 * 1e-5^c V/s in Q16
    function automatic longint unsigned rate_q16(longint c);
        longint unsigned w, u, lo, hi, mant;
        int ip;
        int idx;
        longint unsigned fr;
        w    = 64'd5 * longint'(16384 - c) * 64'd217706;
        u    = (w >> 14) - 64'd217706 + 64'd262144;
        ip   = int'(u >> 16) - 4;
        idx  = int'((u >> 12) & 64'hF);
        fr   = u & 64'hFFF;
        lo   = pow2_frac[idx];
        hi   = pow2_frac[idx + 1];
        mant = lo + (((hi - lo) * fr + 64'd2048) >> 12);
        if (ip >= 0) return mant << ip;
        return (mant + (64'd1 << (-ip - 1))) >> (-ip);
    endfunction

    function automatic t_level slew_next(logic [3:0] ch, logic signed [15:0] target,
                                         logic signed [15:0] sv, logic signed [15:0] rv,
                                         logic signed [15:0] fv);
        t_level res;
        longint held, diff, mag, shp, ctl, mix;
        longint unsigned q;
        res.chan = ch;
        if (ch >= NCH) begin
            res.level = '0;
            return res;
        end
        held = chan_level[ch];
        diff = longint'(target) - held;
        if (diff != 0) begin
            mag = (diff > 0) ? diff : -diff;
            shp = clamp_ctl(longint'(m_shape_base), sv, m_shape_gain);
            if (diff > 0) ctl = clamp_ctl(longint'(m_rise_base), rv, m_rise_gain);
            else          ctl = clamp_ctl(longint'(m_fall_base), fv, m_fall_gain);
            mix = 64'sd335544320 + (mag - 20480) * shp;
            q = ((rate_q16(ctl) * longint'(mix)) >> 22) * longint'(m_time_step);
            q = (q + STEP_DIV / 2) / STEP_DIV;
            if (q > mag) q = mag;
            held = (diff > 0) ? held + longint'(q) : held - longint'(q);
            chan_level[ch] = held[15:0];
        end
        res.level = held[15:0];
        return res;
    endfunction

    // input side: predict at every accepted transfer
    always @(posedge i_clk) begin
        t_level p;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            p = slew_next(i_channel, i_sample_in, i_shape_voltage, i_rise_voltage,
                          i_fall_voltage);
            if (drv_typed) p.level = drv_typed_level;
            level_q.push_back(p);
        end
    end

    // output side: compare in order
    always @(posedge i_clk) begin
        t_level e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (level_q.size() == 0) begin
                $error("output transfer with nothing expected: channel %0d level %0d",
                       o_out_channel, o_sample_out);
                errors++;
            end else begin
                e = level_q.pop_front();
                n_checked++;
                if (o_out_channel !== e.chan) begin
                    $error("out_channel: expected %0d, got %0d", e.chan, o_out_channel);
                    errors++;
                end
                if (o_sample_out !== e.level) begin
                    $error("sample_out: expected %0d, got %0d", e.level, o_sample_out);
                    errors++;
                end
            end
        end
    end

    // receiver stall, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_cnt  <= 300;
            i_out_stall <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_pct);
        end
    end

    task automatic apb_write(logic [2:0] code, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {code, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (code)
            REG_SHAPE_BASE: m_shape_base = value[15:0];
            REG_SHAPE_GAIN: m_shape_gain = value[15:0];
            REG_RISE_BASE:  m_rise_base  = value[14:0];
            REG_RISE_GAIN:  m_rise_gain  = value[15:0];
            REG_FALL_BASE:  m_fall_base  = value[14:0];
            REG_FALL_GAIN:  m_fall_gain  = value[15:0];
            REG_TIME_STEP:  m_time_step  = value[20:0];
            default: ;
        endcase
    endtask

    task automatic load_config(int sb, int sg, int rb, int rg, int fb, int fg, int ts);
        apb_write(REG_SHAPE_BASE, sb);
        apb_write(REG_SHAPE_GAIN, sg);
        apb_write(REG_RISE_BASE, rb);
        apb_write(REG_RISE_GAIN, rg);
        apb_write(REG_FALL_BASE, fb);
        apb_write(REG_FALL_GAIN, fg);
        apb_write(REG_TIME_STEP, ts);
    endtask

    task automatic send(t_row r);
        while ($urandom_range(99) < sender_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_channel       <= r.chan;
        i_sample_in     <= r.target;
        i_shape_voltage <= r.shape_v;
        i_rise_voltage  <= r.rise_v;
        i_fall_voltage  <= r.fall_v;
        drv_typed       <= r.typed;
        drv_typed_level <= r.typed_level;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (level_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_volts();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return $signed(16'($urandom_range(4095))) - 16'sd2048;
            2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'sd0;
        endcase
    endfunction

    function automatic t_row rand_row();
        t_row r;
        logic signed [15:0] h;
        r.chan = 4'($urandom_range(NCH - 1));
        h = chan_level[r.chan];
        case ($urandom_range(9))
            0, 1, 2: r.target = 16'($urandom);
            3, 4:    r.target = h + $signed(16'($urandom_range(64))) - 16'sd32;
            5:       r.target = h;
            6:       r.target = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: r.target = h + $signed(16'($urandom_range(4000))) - 16'sd2000;
        endcase
        r.shape_v     = rand_volts();
        r.rise_v      = rand_volts();
        r.fall_v      = rand_volts();
        r.typed       = 1'b0;
        r.typed_level = '0;
        return r;
    endfunction

    function automatic int rand_q14s();
        case ($urandom_range(3))
            0: return -16384;
            1: return 16384;
            default: return $urandom_range(32768) - 16384;
        endcase
    endfunction

    initial begin
        #2000000;
        $display("poly_slew_limiter_unit test failed");
        $finish;
    end

    initial begin
        t_row dir_rows [$];
        int ph, k;
        errors = 0; n_sent = 0; n_checked = 0;
        sender_pct = 0; recv_pct = 0; hold_req = 0; hold_seen = 0; hold_cnt = 0;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_out_stall = 1'b0;
        i_channel = '0; i_sample_in = '0; i_shape_voltage = '0;
        i_rise_voltage = '0; i_fall_voltage = '0;
        drv_typed = 1'b0; drv_typed_level = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        m_shape_base = '0; m_shape_gain = '0; m_rise_gain = '0; m_fall_gain = '0;
        m_rise_base = RST_KNOB; m_fall_base = RST_KNOB; m_time_step = RST_TIME_STEP;
        for (k = 0; k < NCH; k++) chan_level[k] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // chan, target, shape, rise, fall, typed, level
        dir_rows = '{
            '{4'd3,  16'sd0,      16'sd0,      16'sd0,      16'sd0,      1'b1, 16'sd0},
            '{4'd15, 16'sd0,      16'sh7FFF,   16'sh8000,   16'sh7FFF,   1'b1, 16'sd0},
            '{4'd0,  16'sh7FFF,   16'sd0,      16'sd0,      16'sd0,      1'b0, 16'sd0},
            '{4'd1,  16'sh8000,   16'sd0,      16'sd0,      16'sd0,      1'b0, 16'sd0},
            '{4'd0,  16'sh7FFF,   16'sh7FFF,   16'sh7FFF,   16'sh8000,   1'b0, 16'sd0},
            '{4'd1,  16'sh8000,   16'sh8000,   16'sh8000,   16'sh7FFF,   1'b0, 16'sd0},
            '{4'd2,  16'sd1,      16'sd0,      16'sd0,      16'sd0,      1'b0, 16'sd0},
            '{4'd2,  -16'sd1,     16'sd0,      16'sd0,      16'sd0,      1'b0, 16'sd0},
            '{4'd4,  16'sd2048,   16'sd2048,   16'sd0,      16'sd0,      1'b0, 16'sd0},
            '{4'd4,  -16'sd2048,  -16'sd2048,  16'sd0,      -16'sd2048,  1'b0, 16'sd0},
            '{4'd5,  16'sd0,      16'sh7FFF,   16'sh7FFF,   16'sh7FFF,   1'b1, 16'sd0},
            '{4'd7,  16'sh5555,   16'shAAAA,   16'sh5555,   16'shAAAA,   1'b0, 16'sd0},
            '{4'd8,  16'shAAAA,   16'sh5555,   16'shAAAA,   16'sh5555,   1'b0, 16'sd0},
            '{4'd15, 16'sh7FFF,   16'sd0,      16'sd0,      16'sd0,      1'b0, 16'sd0}
        };
        foreach (dir_rows[k]) send(dir_rows[k]);
        drain();

        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: ; // stay at reset values
                1: load_config(16384, 16384, 0, 16384, 16384, -16384, 1048576);
                2: load_config(-16384, -16384, 16384, -16384, 0, 16384, 0);
                3: load_config(8192, 4096, 4096, 8192, 12000, -8192, 1);
                default: load_config(rand_q14s(), rand_q14s(), $urandom_range(16384),
                                     rand_q14s(), $urandom_range(16384), rand_q14s(),
                                     $urandom_range(1) ? $urandom_range(1048576)
                                                       : $urandom_range(200000));
            endcase
            case (ph % 4)
                0: begin sender_pct = 0;  recv_pct = 0;  end
                1: begin sender_pct = 48; recv_pct = 0;  end
                2: begin sender_pct = 0;  recv_pct = 48; end
                default: begin sender_pct = 11; recv_pct = 11; end
            endcase
            for (k = 0; k < PER_PHASE; k++) begin
                // long output hold-off while input keeps coming
                if (ph == 4 && k == 10) hold_req++;
                // sender pause until everything has come back
                if (ph == 5 && k == 50) drain();
                send(rand_row());
            end
            drain();
        end

        $display("slew limiter run: %0d samples sent, %0d levels checked", n_sent, n_checked);
        $display("covered %0d register settings, idle and stall mixes, long output hold",
                 N_PHASES);
        if (errors == 0) begin
            $display("poly_slew_limiter_unit test passed");
        end else begin
            $display("poly_slew_limiter_unit test failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/psl_pkg.sv
sv/poly_slew_limiter_unit.sv
sv/psl_checker.sv
sim/tb_poly_slew_limiter_unit.sv
